### src/daily_timer_schedule_select_top_assert.svh
// Assertion helpers shared by the schedule select RTL.
// Each macro expects clk and rst to be in scope.
`ifndef DAILY_TIMER_SCHEDULE_SELECT_TOP_ASSERT_SVH
`define DAILY_TIMER_SCHEDULE_SELECT_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DTSS_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DTSS_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`endif

### src/dtss_pkg.sv
// ----------------------------------------------------------------------------
// dtss_pkg
// Shared types and constants for the daily timer schedule select block.
// ----------------------------------------------------------------------------
package dtss_pkg;

  // Table size default and fixed field widths
  localparam int MAX_TIMERS_DEF = 16;
  localparam int TIME_W         = 11;
  localparam int PRESET_W       = 8;
  localparam int BRI_W          = 8;
  localparam int HOUR_W         = 5;
  localparam int MINUTE_W       = 6;
  localparam int KIND_W         = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 11;
  localparam int OUT_IDX_W      = 4;

  localparam logic [BRI_W-1:0]  DEFAULT_BRIGHTNESS = 8'd100;
  localparam logic [TIME_W-1:0] MIN_PER_HOUR       = 11'd60;
  localparam logic [TIME_W-1:0] SUNRISE_RESET      = 11'd360;
  localparam logic [TIME_W-1:0] SUNSET_RESET       = 11'd1080;

  // Timer kinds
  localparam logic [KIND_W-1:0] KIND_REGULAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUNRISE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUNSET  = 2'd2;

  // Item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUNRISE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUNSET       = 2'd3;

  // One timer table entry, 30 bits
  typedef struct packed {
    logic                enabled;
    logic [KIND_W-1:0]   kind;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [PRESET_W-1:0] preset;
    logic [BRI_W-1:0]    brightness;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Per-entry control for one latest-time tracker
  typedef struct packed {
    logic              clear;
    logic              hit;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] now;
  } track_ctl_t;

endpackage

### src/dtss_ram.sv
// ----------------------------------------------------------------------------
// dtss_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dtss_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/dtss_track.sv
// ----------------------------------------------------------------------------
// dtss_track
// Latest-time tracker: keeps the latest hit at or before now and the latest
// hit overall, earliest hit winning ties; reports the first when present.
// ----------------------------------------------------------------------------
module dtss_track #(
  parameter int VW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  dtss_pkg::track_ctl_t ctl,
  input  logic [VW-1:0]       v,
  output logic                found,
  output logic [VW-1:0]       val
);

  import dtss_pkg::*;

  logic              b_ok;
  logic [TIME_W-1:0] b_t;
  logic [VW-1:0]     b_v;
  logic              l_ok;
  logic [TIME_W-1:0] l_t;
  logic [VW-1:0]     l_v;
  logic              b_take;
  logic              l_take;

  // Strictly later replaces, so the earlier entry keeps a tie
  assign b_take = ctl.hit && (ctl.t <= ctl.now) && (!b_ok || (ctl.t > b_t));
  assign l_take = ctl.hit && (!l_ok || (ctl.t > l_t));

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      b_ok <= 1'b0;
      l_ok <= 1'b0;
    end else begin
      if (b_take) b_ok <= 1'b1;
      if (l_take) l_ok <= 1'b1;
    end
  end

  // Candidate time and value
  always_ff @(posedge clk) begin
    if (b_take) begin
      b_t <= ctl.t;
      b_v <= v;
    end
    if (l_take) begin
      l_t <= ctl.t;
      l_v <= v;
    end
  end

  assign found = b_ok || l_ok;
  assign val   = b_ok ? b_v : l_v;

`include "daily_timer_schedule_select_top_assert.svh"

  `DTSS_ASSERT_NEXT(a_clear_empties, ctl.clear, !found, "tracker not empty after clear")
  `DTSS_ASSERT_NEXT(a_hit_found, ctl.hit && !ctl.clear, found, "hit did not register")
  `DTSS_ASSERT_NOW(a_overall_covers, b_ok, l_ok && (l_t >= b_t), "overall latest below bounded")

endmodule

### src/daily_timer_schedule_select_top.sv
// ----------------------------------------------------------------------------
// daily_timer_schedule_select_top
// Daily timer table with a schedule query over the entries in use.
// ----------------------------------------------------------------------------
// Write item: entry stored at the accepting edge, no result.
// Query item: one table read per cycle over the n entries in use, then done
//   strobes with the result.
// busy is low in the done cycle, so the next query can be accepted then.
// Reset (synchronous): control, configuration and tracker flags to defaults; the table is not cleared.
// ----------------------------------------------------------------------------
module daily_timer_schedule_select_top #(
  parameter int MAX_TIMERS = dtss_pkg::MAX_TIMERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              mode,
  input  logic [3:0]                        entry_index,
  input  logic                              entry_enabled,
  input  logic [dtss_pkg::KIND_W-1:0]       entry_kind,
  input  logic [dtss_pkg::HOUR_W-1:0]       entry_hour,
  input  logic [dtss_pkg::MINUTE_W-1:0]     entry_minute,
  input  logic [dtss_pkg::PRESET_W-1:0]     entry_preset,
  input  logic [dtss_pkg::BRI_W-1:0]        entry_brightness,
  input  logic [dtss_pkg::TIME_W-1:0]       now_minutes,
  input  logic                              time_valid,
  input  logic [dtss_pkg::PRESET_W-1:0]     query_preset,
  // result channel
  output logic                              done,
  output logic                              preset_found,
  output logic [dtss_pkg::PRESET_W-1:0]     chosen_preset,
  output logic                              timer_found,
  output logic [dtss_pkg::OUT_IDX_W-1:0]    active_index,
  output logic [dtss_pkg::BRI_W-1:0]        preset_brightness,
  // configuration port
  input  logic                              cfg_we,
  input  logic [dtss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dtss_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import dtss_pkg::*;

  localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  // Configuration registers
  logic [4:0]          timer_count;
  logic [PRESET_W-1:0] preset_count;
  logic [TIME_W-1:0]   sunrise_time;
  logic [TIME_W-1:0]   sunset_time;

  // Control
  logic          state;
  logic [CW-1:0] issue;
  logic [CW-1:0] used;
  logic          pv;
  logic [AW-1:0] pidx;

  // Latched query
  logic                q_now_valid;
  logic [TIME_W-1:0]   q_now;
  logic [PRESET_W-1:0] q_preset;

  logic   accept;
  logic   query_go;
  logic   issue_more;
  logic   wr_en;
  entry_t wr_entry;
  entry_t rd_entry;
  logic [ENTRY_W-1:0] rd_raw;
  logic [TIME_W-1:0]  ent_time;
  logic               ent_timed;
  logic               ent_live;

  track_ctl_t t_ctl;
  track_ctl_t p_ctl;
  track_ctl_t b_ctl;
  logic          t_found;
  logic [AW-1:0] t_val;
  logic          p_found;
  logic [PRESET_W-1:0] p_val;
  logic          b_found;
  logic [BRI_W-1:0] b_val;

  assign accept   = start && !busy;
  assign query_go = accept && (mode == MODE_QUERY);
  assign busy     = (state == S_SCAN);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_count  <= '0;
      preset_count <= '0;
      sunrise_time <= SUNRISE_RESET;
      sunset_time  <= SUNSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMER_COUNT:  timer_count  <= cfg_data[4:0];
        CFG_PRESET_COUNT: preset_count <= cfg_data[PRESET_W-1:0];
        CFG_SUNRISE:      sunrise_time <= cfg_data[TIME_W-1:0];
        CFG_SUNSET:       sunset_time  <= cfg_data[TIME_W-1:0];
        default:          ;
      endcase
    end
  end

  // Entries in use, capped at the table size
  assign used = (int'(timer_count) > MAX_TIMERS) ? CW'(MAX_TIMERS) : CW'(timer_count);

  // Table write from a write item
  assign wr_en = accept && (mode == MODE_WRITE) && (int'(entry_index) < MAX_TIMERS);
  assign wr_entry = '{enabled:    entry_enabled,
                      kind:       entry_kind,
                      hour:       entry_hour,
                      minute:     entry_minute,
                      preset:     entry_preset,
                      brightness: entry_brightness};

  dtss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TIMERS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(entry_index)),
    .wdata (wr_entry),
    .raddr (issue[AW-1:0]),
    .rdata (rd_raw)
  );

  assign rd_entry = entry_t'(rd_raw);

  // Scan sequencer: one read issued per cycle, read data and its index registered before use
  assign issue_more = (issue < used);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          pv <= 1'b0;
          if (query_go) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          pv <= issue_more;
          if (!issue_more && !pv) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (query_go) begin
      issue <= '0;
    end else if ((state == S_SCAN) && issue_more) begin
      issue <= issue + 1'b1;
    end
    pidx <= issue[AW-1:0];
  end

  // Query fields held for the scan
  always_ff @(posedge clk) begin
    if (query_go) begin
      q_now       <= now_minutes;
      q_now_valid <= time_valid;
      q_preset    <= query_preset;
    end
  end

  // Time of day of the entry just read
  always_comb begin
    ent_time  = '0;
    ent_timed = 1'b1;
    case (rd_entry.kind)
      KIND_REGULAR: ent_time = TIME_W'(rd_entry.hour) * MIN_PER_HOUR
                               + TIME_W'(rd_entry.minute);
      KIND_SUNRISE: ent_time = sunrise_time;
      KIND_SUNSET:  ent_time = sunset_time;
      default:      ent_timed = 1'b0;
    endcase
  end

  assign ent_live = pv && rd_entry.enabled && ent_timed;

  assign t_ctl = '{clear: query_go, hit: ent_live, t: ent_time, now: q_now};
  assign p_ctl = '{clear: query_go, hit: ent_live && (rd_entry.preset < preset_count),
                   t: ent_time, now: q_now};
  assign b_ctl = '{clear: query_go, hit: ent_live && (rd_entry.preset == q_preset),
                   t: ent_time, now: q_now};

  dtss_track #(.VW(AW)) u_timer (
    .clk (clk), .rst (rst), .ctl (t_ctl), .v (pidx), .found (t_found), .val (t_val)
  );

  dtss_track #(.VW(PRESET_W)) u_preset (
    .clk (clk), .rst (rst), .ctl (p_ctl), .v (rd_entry.preset),
    .found (p_found), .val (p_val)
  );

  dtss_track #(.VW(BRI_W)) u_bright (
    .clk (clk), .rst (rst), .ctl (b_ctl), .v (rd_entry.brightness),
    .found (b_found), .val (b_val)
  );

  // Result beat
  always_ff @(posedge clk) begin
    if ((state == S_SCAN) && !issue_more && !pv) begin
      preset_found      <= q_now_valid && p_found;
      chosen_preset     <= (q_now_valid && p_found) ? p_val : '0;
      timer_found       <= q_now_valid && t_found;
      active_index      <= (q_now_valid && t_found) ? OUT_IDX_W'(t_val) : '0;
      preset_brightness <= b_found ? b_val : DEFAULT_BRIGHTNESS;
    end
  end

`include "daily_timer_schedule_select_top_assert.svh"

  `DTSS_ASSERT_NOW(a_done_not_busy, done, !busy, "busy during result beat")
  `DTSS_ASSERT_NEXT(a_query_busy, query_go, busy && !done, "query did not start scan")
  `DTSS_ASSERT_NEXT(a_single_beat, done, !done, "more than one beat per query")
  `DTSS_ASSERT_NOW(a_preset_implies_timer, done && preset_found, timer_found,
                   "preset chosen without a timer")
  `DTSS_ASSERT_NOW(a_no_clock_nothing, done && !q_now_valid,
                   !preset_found && !timer_found, "choice made without valid clock")

endmodule
